// ===== sv/text_line_column_tracker_core_defines.svh =====
// ---------------------------------------------------------------------------
// text_line_column_tracker_core_defines.svh
// Assertion macros used by the checker file of the line/column tracker.
// ---------------------------------------------------------------------------
`ifndef TEXT_LINE_COLUMN_TRACKER_CORE_DEFINES_SVH
`define TEXT_LINE_COLUMN_TRACKER_CORE_DEFINES_SVH

// Checked on every edge, reset included.
`define TLTC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define TLTC_ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== sv/tltc_pkg.sv =====
// ---------------------------------------------------------------------------
// tltc_pkg
// Payload types and character constants of the line/column tracker.
// ---------------------------------------------------------------------------
package tltc_pkg;

   localparam logic [7:0]  CHAR_LF    = 8'h0A;
   localparam logic [7:0]  CHAR_CR    = 8'h0D;
   localparam logic [31:0] OUT_MAX    = 32'hFFFF_FFFF;
   localparam logic [31:0] LINE_FIRST = 32'd1;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] line_number;
      logic [31:0] column_number;
   } rsp_type;

endpackage

// ===== sv/text_line_column_tracker_core.sv =====
// ---------------------------------------------------------------------------
// text_line_column_tracker_core
// Streams text one byte per request and returns its line and column number.
// ---------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_data  (text_byte, last_byte)
//  rsp      out        rsp_valid / rsp_ready  rsp_data  (line_number, column_number)
//
//  One request per cycle sustained while rsp_ready stays high; each result
//  passes through the input register, then the result register.
//  The tracker state steps when a request moves from the input register into
//  the result register.
//  Reset (synchronous) empties both registers and returns the tracker to
//  line 1, offset 0. A request flagged last_byte returns the tracker there afterwards.
//  A stall on rsp_ready holds the result; the input register still takes
//  one more request, and req_ready then drops until the result is taken.
// ---------------------------------------------------------------------------
module text_line_column_tracker_core #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tltc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tltc_pkg::rsp_type rsp_data
);
   import tltc_pkg::*;

   logic    hold_valid;
   req_type hold_data;
   logic    can_load;
   logic    advance;
   rsp_type step_result;

   // A held request advances whenever the result register has room.
   assign advance = hold_valid && can_load;

   tltc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   // Line/column state plus the compare-and-increment update for one byte.
   tltc_tracker #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_tracker (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req_data (hold_data),
      .rsp_data (step_result)
   );

   tltc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (step_result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

// ===== sv/tltc_in_reg.sv =====
// ---------------------------------------------------------------------------
// tltc_in_reg
// Input register: holds one request until the tracker consumes it.
// ---------------------------------------------------------------------------
module tltc_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tltc_pkg::req_type req_data,
   input  logic              advance,
   output logic              hold_valid,
   output tltc_pkg::req_type hold_data
);
   import tltc_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;
endmodule

// ===== sv/tltc_tracker.sv =====
// ---------------------------------------------------------------------------
// tltc_tracker
// Line/column state and the per-byte update; state moves on each step.
// ---------------------------------------------------------------------------
module tltc_tracker #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  tltc_pkg::req_type req_data,
   output tltc_pkg::rsp_type rsp_data
);
   import tltc_pkg::*;

   localparam int WIDE_WIDTH = (OFFSET_WIDTH + 1 > 33) ? OFFSET_WIDTH + 1 : 33;

   logic [OFFSET_WIDTH-1:0] position_ff, position_in;
   logic [31:0]             line_count_ff, line_count_in;
   logic                    open_break_ff, open_break_in;
   logic                    open_is_cr_ff, open_is_cr_in;
   logic                    pending_ff, pending_in;
   logic [OFFSET_WIDTH-1:0] break_pos_ff, break_pos_in;
   logic                    break_seen_ff, break_seen_in;

   logic                    is_cr, is_brk, is_pair, line_step;
   logic [31:0]             line_now;
   logic [OFFSET_WIDTH:0]   pos_plus;
   logic [OFFSET_WIDTH-1:0] pos_diff;
   logic [WIDE_WIDTH-1:0]   col_wide;
   logic [31:0]             col_now;

   always_comb begin
      is_cr     = (req_data.text_byte == CHAR_CR);
      is_brk    = is_cr || (req_data.text_byte == CHAR_LF);
      is_pair   = open_break_ff && is_brk && (is_cr != open_is_cr_ff);
      // a pair closed last byte, or a lone break ends here
      line_step = pending_ff || (open_break_ff && !is_pair);
      line_now  = (line_step && (line_count_ff != OUT_MAX)) ?
                  line_count_ff + 32'd1 : line_count_ff;

      pos_plus = {1'b0, position_ff} + {{OFFSET_WIDTH{1'b0}}, 1'b1};
      pos_diff = position_ff - break_pos_ff;
      col_wide = break_seen_ff ? WIDE_WIDTH'(pos_diff) : WIDE_WIDTH'(pos_plus);
      col_now  = (col_wide > WIDE_WIDTH'(OUT_MAX)) ? OUT_MAX : col_wide[31:0];

      rsp_data.line_number   = line_now;
      rsp_data.column_number = col_now;
   end

   always_comb begin
      position_in   = position_ff;
      line_count_in = line_count_ff;
      open_break_in = open_break_ff;
      open_is_cr_in = open_is_cr_ff;
      pending_in    = pending_ff;
      break_pos_in  = break_pos_ff;
      break_seen_in = break_seen_ff;
      if (step) begin
         if (req_data.last_byte) begin
            position_in   = '0;
            line_count_in = LINE_FIRST;
            open_break_in = 1'b0;
            open_is_cr_in = 1'b0;
            pending_in    = 1'b0;
            break_pos_in  = '0;
            break_seen_in = 1'b0;
         end else begin
            line_count_in = line_now;
            pending_in    = is_pair;
            open_break_in = is_brk && !is_pair;
            open_is_cr_in = is_brk && !is_pair && is_cr;
            // a break at offset 0 never anchors a column
            if (is_brk && (position_ff != '0)) begin
               break_pos_in  = position_ff;
               break_seen_in = 1'b1;
            end
            if (position_ff != '1) begin
               position_in = pos_plus[OFFSET_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         line_count_ff <= LINE_FIRST;
         open_break_ff <= 1'b0;
         open_is_cr_ff <= 1'b0;
         pending_ff    <= 1'b0;
         break_pos_ff  <= '0;
         break_seen_ff <= 1'b0;
      end else begin
         position_ff   <= position_in;
         line_count_ff <= line_count_in;
         open_break_ff <= open_break_in;
         open_is_cr_ff <= open_is_cr_in;
         pending_ff    <= pending_in;
         break_pos_ff  <= break_pos_in;
         break_seen_ff <= break_seen_in;
      end
   end
endmodule

// ===== sv/tltc_out_reg.sv =====
// ---------------------------------------------------------------------------
// tltc_out_reg
// Result register: holds one result until the consumer takes it.
// ---------------------------------------------------------------------------
module tltc_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  tltc_pkg::rsp_type load_data,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tltc_pkg::rsp_type rsp_data
);
   import tltc_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = can_load ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

// ===== sv/tltc_checker.sv =====
// ---------------------------------------------------------------------------
// tltc_checker
// Port-level checks of the line/column tracker, bound to the top level.
// ---------------------------------------------------------------------------
`include "text_line_column_tracker_core_defines.svh"

module tltc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tltc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tltc_pkg::rsp_type rsp_data
);
   import tltc_pkg::*;

   logic rsp_stall;
   logic line_is_zero;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign line_is_zero = (rsp_data.line_number == 32'd0);

   // a stalled result stays put until taken
   property p_rsp_holds;
      rsp_stall |=> (rsp_valid && $stable(rsp_data));
   endproperty

   `TLTC_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")
   `TLTC_ASSERT_RUN(a_ready_empty, clock, reset, !rsp_valid |-> req_ready, "stall while empty")
   `TLTC_ASSERT_RUN(a_line_nonzero, clock, reset, rsp_valid |-> !line_is_zero, "line number zero")
   `TLTC_ASSERT_RUN(a_rsp_holds, clock, reset, p_rsp_holds, "stalled result changed")
endmodule

bind text_line_column_tracker_core tltc_checker u_checker (.*);
